@@ design/disc_segment_closest_point_unit_assert.svh @@
// Assertion macros for the disc segment closest point unit checker.
`ifndef DISC_SEGMENT_CLOSEST_POINT_UNIT_ASSERT_SVH
`define DISC_SEGMENT_CLOSEST_POINT_UNIT_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define DSCP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define DSCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dscp_pkg.sv @@
// Shared widths, payload types and selection codes for the closest point unit.
package dscp_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 15;
  localparam int DIST_BITS   = 33;

  localparam int DIFF_W = COORD_BITS + 1;           // difference of two coordinates
  localparam int PROD_W = 2 * DIFF_W;               // signed product of two differences
  localparam int LEN_W  = 2 * COORD_BITS + 1;       // squared length, squared distance
  localparam int SQ_W   = 2 * COORD_BITS;           // one squared axis distance
  localparam int R2_W   = 2 * RADIUS_BITS;
  localparam int CMP_W  = (LEN_W > R2_W) ? LEN_W : R2_W;
  localparam int PLO_W  = (LEN_W + 1) / 2;          // low slice of the projection
  localparam int PHI_W  = LEN_W - PLO_W;            // high slice of the projection
  localparam int PLO_PW = COORD_BITS + PLO_W;
  localparam int PHI_PW = COORD_BITS + PHI_W;
  localparam int NUM_W  = COORD_BITS + LEN_W;       // interpolation numerator
  localparam int LANES  = 2;                        // one divider lane per axis

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_INTERP
  } sel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [RADIUS_BITS-1:0] disc_radius;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic        [DIST_BITS-1:0]  dist_sq;
    logic                         overlap;
  } out_res_t;

  // Per-request data that rides alongside the divider.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    sel_t                         sel;
    logic                         neg_x;
    logic                         neg_y;
    logic        [R2_W-1:0]       r2;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [LEN_W-1:0]       len2;
    logic [LEN_W-1:0]       proj;
    logic [COORD_BITS-1:0]  mag_x;
    logic [COORD_BITS-1:0]  mag_y;
  } div_req_t;

  typedef struct packed {
    side_t                  side;
    logic [COORD_BITS-1:0]  q_x;
    logic [COORD_BITS-1:0]  q_y;
  } div_res_t;

endpackage

@@ design/dscp_setup.sv @@
// Front stages: differences, products, projection and endpoint selection.
module dscp_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  dscp_pkg::in_req_t  in_req,
  output logic               setup_valid,
  output dscp_pkg::div_req_t setup_data
);
  import dscp_pkg::*;

  logic                     v1;
  in_req_t                  req1;
  logic signed [DIFF_W-1:0] dx1, dy1, vx1, vy1;

  logic                     v2;
  in_req_t                  req2;
  logic signed [DIFF_W-1:0] dx2, dy2;
  logic signed [PROD_W-1:0] dxx2, dyy2, vdx2, vdy2;
  logic        [R2_W-1:0]   r2_2;

  logic signed [PROD_W-1:0] len2_s, dot_s;
  sel_t                     sel_s;
  logic        [DIFF_W-1:0] abs_x, abs_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      setup_valid <= 1'b0;
    end else if (adv) begin
      v1          <= in_valid;
      v2          <= v1;
      setup_valid <= v2;
    end
  end

  // Stage 1: segment direction and start-to-centre vector.
  always_ff @(posedge clk) begin
    if (adv) begin
      req1 <= in_req;
      dx1  <= DIFF_W'(in_req.seg_end_x) - DIFF_W'(in_req.seg_start_x);
      dy1  <= DIFF_W'(in_req.seg_end_y) - DIFF_W'(in_req.seg_start_y);
      vx1  <= DIFF_W'(in_req.center_x) - DIFF_W'(in_req.seg_start_x);
      vy1  <= DIFF_W'(in_req.center_y) - DIFF_W'(in_req.seg_start_y);
    end
  end

  // Stage 2: products.
  always_ff @(posedge clk) begin
    if (adv) begin
      req2 <= req1;
      dx2  <= dx1;
      dy2  <= dy1;
      dxx2 <= PROD_W'(dx1) * PROD_W'(dx1);
      dyy2 <= PROD_W'(dy1) * PROD_W'(dy1);
      vdx2 <= PROD_W'(vx1) * PROD_W'(dx1);
      vdy2 <= PROD_W'(vy1) * PROD_W'(dy1);
      r2_2 <= R2_W'(req1.disc_radius) * R2_W'(req1.disc_radius);
    end
  end

  // Stage 3: sums and endpoint classification.
  always_comb begin
    len2_s = dxx2 + dyy2;
    dot_s  = vdx2 + vdy2;
    priority if (len2_s == '0 || dot_s[PROD_W-1] || dot_s == '0) begin
      sel_s = SEL_START;
    end else if (dot_s >= len2_s) begin
      sel_s = SEL_END;
    end else begin
      sel_s = SEL_INTERP;
    end
    abs_x = dx2[DIFF_W-1] ? DIFF_W'(-dx2) : DIFF_W'(dx2);
    abs_y = dy2[DIFF_W-1] ? DIFF_W'(-dy2) : DIFF_W'(dy2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      setup_data.side.cx    <= req2.center_x;
      setup_data.side.cy    <= req2.center_y;
      setup_data.side.sx    <= req2.seg_start_x;
      setup_data.side.sy    <= req2.seg_start_y;
      setup_data.side.ex    <= req2.seg_end_x;
      setup_data.side.ey    <= req2.seg_end_y;
      setup_data.side.sel   <= sel_s;
      setup_data.side.neg_x <= dx2[DIFF_W-1];
      setup_data.side.neg_y <= dy2[DIFF_W-1];
      setup_data.side.r2    <= r2_2;
      setup_data.len2       <= len2_s[LEN_W-1:0];
      setup_data.proj       <= dot_s[LEN_W-1:0];
      setup_data.mag_x      <= abs_x[COORD_BITS-1:0];
      setup_data.mag_y      <= abs_y[COORD_BITS-1:0];
    end
  end

endmodule

@@ design/dscp_divide.sv @@
// Interpolation stages: split multiply, then one restoring quotient bit per stage.
module dscp_divide (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               setup_valid,
  input  dscp_pkg::div_req_t setup_data,
  output logic               div_valid,
  output dscp_pkg::div_res_t div_data
);
  import dscp_pkg::*;

  logic                  m_v;
  side_t                 m_side;
  logic [LEN_W-1:0]      m_len;
  logic [PLO_PW-1:0]     plo [LANES];
  logic [PHI_PW-1:0]     phi [LANES];
  logic [COORD_BITS-1:0] mag [LANES];

  logic                  sv    [COORD_BITS+1];
  side_t                 sside [COORD_BITS+1];
  logic [LEN_W-1:0]      slen  [COORD_BITS];
  logic [LEN_W-1:0]      srem  [COORD_BITS][LANES];
  logic [COORD_BITS-1:0] slow  [COORD_BITS+1][LANES];

  logic [NUM_W-1:0]      num   [LANES];
  logic [LEN_W:0]        trial [COORD_BITS][LANES];
  logic                  take  [COORD_BITS][LANES];

  assign mag[0] = setup_data.mag_x;
  assign mag[1] = setup_data.mag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      for (int k = 0; k <= COORD_BITS; k++) begin
        sv[k] <= 1'b0;
      end
    end else if (adv) begin
      m_v   <= setup_valid;
      sv[0] <= m_v;
      for (int k = 0; k < COORD_BITS; k++) begin
        sv[k+1] <= sv[k];
      end
    end
  end

  // Partial products of magnitude times projection.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= setup_data.side;
      m_len  <= setup_data.len2;
      for (int l = 0; l < LANES; l++) begin
        plo[l] <= PLO_PW'(mag[l]) * PLO_PW'(setup_data.proj[PLO_W-1:0]);
        phi[l] <= PHI_PW'(mag[l]) * PHI_PW'(setup_data.proj[LEN_W-1:PLO_W]);
      end
    end
  end

  // Quotient is below the magnitude, so the top LEN_W bits start below len2.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = (NUM_W'(phi[l]) << PLO_W) + NUM_W'(plo[l]);
    end
    for (int k = 0; k < COORD_BITS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = {srem[k][l], slow[k][l][COORD_BITS-1]};
        take[k][l]  = trial[k][l] >= {1'b0, slen[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sside[0] <= m_side;
      slen[0]  <= m_len;
      for (int l = 0; l < LANES; l++) begin
        srem[0][l] <= num[l][NUM_W-1:COORD_BITS];
        slow[0][l] <= num[l][COORD_BITS-1:0];
      end
      for (int k = 0; k < COORD_BITS; k++) begin
        sside[k+1] <= sside[k];
        for (int l = 0; l < LANES; l++) begin
          // shift in the next dividend bit's slot with the quotient bit
          slow[k+1][l] <= {slow[k][l][COORD_BITS-2:0], take[k][l]};
        end
      end
      // The last stage keeps only its quotient bit.
      for (int k = 0; k < COORD_BITS - 1; k++) begin
        slen[k+1] <= slen[k];
        for (int l = 0; l < LANES; l++) begin
          srem[k+1][l] <= take[k][l] ? LEN_W'(trial[k][l] - {1'b0, slen[k]})
                                     : trial[k][l][LEN_W-1:0];
        end
      end
    end
  end

  assign div_valid     = sv[COORD_BITS];
  assign div_data.side = sside[COORD_BITS];
  assign div_data.q_x  = slow[COORD_BITS][0];
  assign div_data.q_y  = slow[COORD_BITS][1];

endmodule

@@ design/dscp_finish.sv @@
// Back stages: closest point, squared distance, overlap and output buffering.
module dscp_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               div_valid,
  input  dscp_pkg::div_res_t div_data,
  input  logic               out_ready,
  output logic               out_valid,
  output dscp_pkg::out_res_t out_res,
  output logic               adv
);
  import dscp_pkg::*;

  logic signed [COORD_BITS-1:0] nx, ny;

  logic                         f1_v;
  logic signed [COORD_BITS-1:0] f1_nx, f1_ny;
  logic signed [DIFF_W-1:0]     f1_ax, f1_ay;
  logic        [R2_W-1:0]       f1_r2;

  logic                         f2_v;
  logic signed [COORD_BITS-1:0] f2_nx, f2_ny;
  logic signed [PROD_W-1:0]     sqx_full, sqy_full;
  logic        [SQ_W-1:0]       f2_sqx, f2_sqy;
  logic        [R2_W-1:0]       f2_r2;

  logic [LEN_W-1:0] sq_dist;
  out_res_t         res;
  logic             skid_v;
  out_res_t         skid_res;

  assign adv = !skid_v;

  always_comb begin
    unique case (div_data.side.sel)
      SEL_START: begin
        nx = div_data.side.sx;
        ny = div_data.side.sy;
      end
      SEL_END: begin
        nx = div_data.side.ex;
        ny = div_data.side.ey;
      end
      SEL_INTERP: begin
        nx = div_data.side.neg_x ? div_data.side.sx - div_data.q_x
                                 : div_data.side.sx + div_data.q_x;
        ny = div_data.side.neg_y ? div_data.side.sy - div_data.q_y
                                 : div_data.side.sy + div_data.q_y;
      end
      default: begin
        nx = div_data.side.sx;
        ny = div_data.side.sy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (adv) begin
      f1_v <= div_valid;
      f2_v <= f1_v;
    end
  end

  assign sqx_full = PROD_W'(f1_ax) * PROD_W'(f1_ax);
  assign sqy_full = PROD_W'(f1_ay) * PROD_W'(f1_ay);

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_nx  <= nx;
      f1_ny  <= ny;
      f1_ax  <= DIFF_W'(div_data.side.cx) - DIFF_W'(nx);
      f1_ay  <= DIFF_W'(div_data.side.cy) - DIFF_W'(ny);
      f1_r2  <= div_data.side.r2;
      f2_nx  <= f1_nx;
      f2_ny  <= f1_ny;
      f2_sqx <= sqx_full[SQ_W-1:0];
      f2_sqy <= sqy_full[SQ_W-1:0];
      f2_r2  <= f1_r2;
    end
  end

  always_comb begin
    sq_dist     = LEN_W'(f2_sqx) + LEN_W'(f2_sqy);
    res.near_x  = f2_nx;
    res.near_y  = f2_ny;
    res.dist_sq = DIST_BITS'(sq_dist);
    res.overlap = CMP_W'(sq_dist) <= CMP_W'(f2_r2);
  end

  // Output register plus one skid entry; the pipe holds only when the skid is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= skid_v || f2_v;
      skid_v    <= 1'b0;
    end else if (f2_v && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_v ? skid_res : res;
    end
    if (out_valid && !out_ready && !skid_v) begin
      skid_res <= res;
    end
  end

endmodule

@@ design/disc_segment_closest_point_unit.sv @@
// Top level of the disc to segment closest point unit.
//
//   channel | handshake            | payload                | direction
//   --------+----------------------+------------------------+----------
//   input   | in_valid / in_ready  | in_req  (in_req_t)     | in
//   output  | out_valid / out_ready| out_res (out_res_t)    | out
//
// Takes one request per cycle unless the pipe holds; the interpolation uses
// a one-bit-per-stage restoring divider.
// rst is synchronous and clears every valid bit and the skid entry.
// An output register with one skid entry follows the pipe: a result that
// waits leaves in_ready high until the skid fills, then the whole pipe holds
// and nothing is lost or repeated.
module disc_segment_closest_point_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dscp_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output dscp_pkg::out_res_t out_res
);
  import dscp_pkg::*;

  logic     adv;
  logic     setup_valid;
  div_req_t setup_data;
  logic     div_valid;
  div_res_t div_data;

  // Advance every stage together; accept a request whenever the pipe moves.
  assign in_ready = adv;

  // Form direction, projection and endpoint choice.
  dscp_setup u_setup (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_req      (in_req),
    .setup_valid (setup_valid),
    .setup_data  (setup_data)
  );

  // Scale each axis by projection over squared length, truncating.
  dscp_divide u_divide (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .setup_valid (setup_valid),
    .setup_data  (setup_data),
    .div_valid   (div_valid),
    .div_data    (div_data)
  );

  // Build the point, the squared distance and the overlap flag; buffer it.
  dscp_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .div_valid (div_valid),
    .div_data  (div_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .adv       (adv)
  );

endmodule

@@ design/dscp_checker.sv @@
// Port-level checker for the closest point unit and its bind.
`include "disc_segment_closest_point_unit_assert.svh"

module dscp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dscp_pkg::out_res_t out_res
);
  import dscp_pkg::*;

  `DSCP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_res), "result changed while stalled")
  `DSCP_ASSERT_NOW(a_ready_cause, clk, rst, !in_ready, $past(out_valid && !out_ready), "request refused without a held result")
  `DSCP_ASSERT_NOW(a_ready_free, clk, rst, !out_valid, in_ready, "request refused with output empty")
  `DSCP_ASSERT_NOW(a_zero_overlap, clk, rst, out_valid && out_res.dist_sq == '0, out_res.overlap, "zero distance without overlap")

endmodule

bind disc_segment_closest_point_unit dscp_checker u_dscp_checker (.*);
